@@ rtl/dtke_pkg.sv @@
// ----------------------------------------------------------------------------
// dtke_pkg
// Types and codes shared by the date and time keypad entry block.
// ----------------------------------------------------------------------------
package dtke_pkg;

    // operation codes of a key event
    localparam logic [2:0] OP_DIGIT     = 3'd0;
    localparam logic [2:0] OP_JUMP      = 3'd1;
    localparam logic [2:0] OP_LEFT      = 3'd2;
    localparam logic [2:0] OP_RIGHT     = 3'd3;
    localparam logic [2:0] OP_INCREMENT = 3'd4;
    localparam logic [2:0] OP_DECREMENT = 3'd5;
    localparam logic [2:0] OP_CLEAR     = 3'd6;
    localparam logic [2:0] OP_CONFIRM   = 3'd7;

    // field codes
    localparam logic [2:0] SLOT_YEAR   = 3'd0;
    localparam logic [2:0] SLOT_MONTH  = 3'd1;
    localparam logic [2:0] SLOT_DAY    = 3'd2;
    localparam logic [2:0] SLOT_HOUR   = 3'd3;
    localparam logic [2:0] SLOT_MINUTE = 3'd4;
    localparam logic [2:0] SLOT_SECOND = 3'd5;

    // static field limits
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [13:0] MONTH_MAX  = 14'd12;
    localparam logic [13:0] DAY_MAX    = 14'd31;
    localparam logic [13:0] HOUR_MAX   = 14'd23;
    localparam logic [13:0] MINSEC_MAX = 14'd59;

    // reset value of the year field
    localparam logic [13:0] YEAR_RESET = 14'd2000;

    // digits held for a year before the fourth one completes it
    localparam logic [1:0] YEAR_HELD_DIGITS = 2'd3;

    // one key event request
    typedef struct packed {
        logic [2:0]  operation;
        logic        load_request;
        logic [3:0]  digit;
        logic [2:0]  target_field;
        logic [13:0] field_value;
    } t_in_item;

    // editor state after one request
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  active_slot;
        logic [9:0]  pending_digits;
        logic [1:0]  pending_count;
        logic [2:0]  last_edited_slot;
        logic        confirmed;
    } t_out_item;

endpackage

@@ rtl/date_time_keypad_entry.sv @@
// ----------------------------------------------------------------------------
// date_time_keypad_entry
// Keypad editor for a six-field date and time with cursor and digit entry.
// ----------------------------------------------------------------------------
// Takes one key request per cycle while results are being taken, and returns one
// result per request: the six fields, the cursor, the pending entry and the last
// edited field, taken after the request has been applied. A request is held in an
// input register and is applied, once the output register is free, by a single
// pass of logic over the field registers; the result sits in an output register
// until it is taken, and a further request is taken into the input register
// meanwhile. The rate of one request per cycle is set by the update of the field
// and cursor registers. Typed and stepped days are limited by the stored month and
// the Gregorian leap rule of the stored year; a loaded day is clamped to 31.
module date_time_keypad_entry
    import dtke_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // request and result registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    // editor state
    logic [13:0] r_year,  n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day,   n_day;
    logic [4:0]  r_hour,  n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;
    logic [2:0]  r_slot,  n_slot;
    logic [2:0]  r_edited, n_edited;
    logic [9:0]  r_entry, n_entry;
    logic [1:0]  r_count, n_count;
    logic        n_conf;

    logic process;

    // handshake: a request moves on when the result register is free
    assign process     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || process;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // leap year from the stored year, by reciprocal of one hundred
    logic [26:0] year_prod;
    logic [7:0]  year_cent;
    logic [14:0] cent_x100;
    logic [13:0] year_rem;
    logic        leap;

    assign year_prod = 27'(r_year) * 27'd5243;
    assign year_cent = year_prod[26:19];
    assign cent_x100 = {1'b0, year_cent, 6'b0} + {2'b0, year_cent, 5'b0} + {5'b0, year_cent, 2'b0};
    assign year_rem  = r_year - cent_x100[13:0];
    assign leap      = (r_year[1:0] == 2'b00) && ((year_rem != 14'd0) || (year_cent[1:0] == 2'b00));

    // days in the stored month
    logic [13:0] day_limit;
    always_comb begin
        unique case (r_month)
            4'd2:                         day_limit = leap ? 14'd29 : 14'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      day_limit = 14'd30;
            default:                      day_limit = 14'd31;
        endcase
    end

    // range of the field under the cursor, value held in it
    logic [13:0] cur_lo, cur_hi, cur_val;
    always_comb begin
        cur_lo = (r_slot <= SLOT_DAY) ? 14'd1 : 14'd0;
        unique case (r_slot)
            SLOT_YEAR:  cur_hi = YEAR_MAX;
            SLOT_MONTH: cur_hi = MONTH_MAX;
            SLOT_DAY:   cur_hi = day_limit;
            SLOT_HOUR:  cur_hi = HOUR_MAX;
            default:    cur_hi = MINSEC_MAX;
        endcase
        unique case (r_slot)
            SLOT_YEAR:   cur_val = r_year;
            SLOT_MONTH:  cur_val = {10'd0, r_month};
            SLOT_DAY:    cur_val = {9'd0, r_day};
            SLOT_HOUR:   cur_val = {9'd0, r_hour};
            SLOT_MINUTE: cur_val = {8'd0, r_minute};
            default:     cur_val = {8'd0, r_second};
        endcase
    end

    // static range of the load target, clamped load value
    logic [13:0] tgt_lo, tgt_hi, load_val;
    always_comb begin
        tgt_lo = (r_in.target_field <= SLOT_DAY) ? 14'd1 : 14'd0;
        unique case (r_in.target_field)
            SLOT_YEAR:  tgt_hi = YEAR_MAX;
            SLOT_MONTH: tgt_hi = MONTH_MAX;
            SLOT_DAY:   tgt_hi = DAY_MAX;
            SLOT_HOUR:  tgt_hi = HOUR_MAX;
            default:    tgt_hi = MINSEC_MAX;
        endcase
        if (r_in.field_value < tgt_lo) begin
            load_val = tgt_lo;
        end else if (r_in.field_value > tgt_hi) begin
            load_val = tgt_hi;
        end else begin
            load_val = r_in.field_value;
        end
    end

    // entry with the new digit appended, and the digit scaled as a tens digit
    logic [13:0] digit_val, digit_tens, pend_val;
    assign pend_val   = {4'd0, r_entry};
    assign digit_val  = {1'b0, r_entry, 3'b0} + {3'b0, r_entry, 1'b0} + {10'd0, r_in.digit};
    assign digit_tens = {7'd0, r_in.digit, 3'b0} + {9'd0, r_in.digit, 1'b0};

    // stepped values with wrap
    logic [13:0] step_up, step_dn, cur_inc, cur_dec;
    assign cur_inc = cur_val + 14'd1;
    assign cur_dec = cur_val - 14'd1;
    assign step_up = (cur_inc > cur_hi) ? cur_lo : cur_inc;
    assign step_dn = (cur_val <= cur_lo) ? cur_hi : ((cur_dec > cur_hi) ? cur_lo : cur_dec);

    // key event decode: a checked store, a forced store or a load
    logic        try_en, try_adv, force_en, ld_en, clr_en, commit_en;
    logic [13:0] try_val, force_val;
    logic        tgt_ok;
    assign tgt_ok = (r_in.target_field <= SLOT_SECOND);

    always_comb begin
        try_en    = 1'b0;
        try_adv   = 1'b0;
        try_val   = pend_val;
        force_en  = 1'b0;
        force_val = step_up;
        ld_en     = 1'b0;
        clr_en    = 1'b0;
        commit_en = 1'b0;
        n_conf    = 1'b0;
        n_slot    = r_slot;
        n_entry   = r_entry;
        n_count   = r_count;
        if (r_in.load_request) begin
            ld_en = tgt_ok;
        end else begin
            unique case (r_in.operation)
                OP_DIGIT: begin
                    if (r_in.digit <= 4'd9) begin
                        if (r_slot == SLOT_YEAR) begin
                            if (r_count == YEAR_HELD_DIGITS) begin
                                try_en  = 1'b1;
                                try_adv = 1'b1;
                                try_val = digit_val;
                                clr_en  = 1'b1;
                            end else begin
                                n_entry = digit_val[9:0];
                                n_count = r_count + 2'd1;
                            end
                        end else if (r_count == 2'd0) begin
                            if (digit_tens <= cur_hi) begin
                                n_entry = {6'd0, r_in.digit};
                                n_count = 2'd1;
                            end else begin
                                try_en  = 1'b1;
                                try_adv = 1'b1;
                                try_val = {10'd0, r_in.digit};
                                clr_en  = 1'b1;
                            end
                        end else begin
                            try_en  = 1'b1;
                            try_adv = 1'b1;
                            try_val = digit_val;
                            clr_en  = 1'b1;
                        end
                    end
                end
                OP_JUMP: begin
                    if (tgt_ok) begin
                        commit_en = 1'b1;
                        n_slot    = r_in.target_field;
                    end
                end
                OP_LEFT: begin
                    commit_en = 1'b1;
                    if (r_slot != SLOT_YEAR) n_slot = r_slot - 3'd1;
                end
                OP_RIGHT: begin
                    commit_en = 1'b1;
                    if (r_slot != SLOT_SECOND) n_slot = r_slot + 3'd1;
                end
                OP_INCREMENT: begin
                    force_en  = 1'b1;
                    force_val = step_up;
                    clr_en    = 1'b1;
                end
                OP_DECREMENT: begin
                    force_en  = 1'b1;
                    force_val = step_dn;
                    clr_en    = 1'b1;
                end
                OP_CLEAR: begin
                    clr_en = 1'b1;
                end
                OP_CONFIRM: begin
                    commit_en = 1'b1;
                    n_conf    = 1'b1;
                end
                default: begin
                    clr_en = 1'b0;
                end
            endcase
        end
        // commit of a pending entry, never moves the cursor
        if (commit_en) begin
            try_en = (r_count != 2'd0);
            try_val = pend_val;
            clr_en = 1'b1;
        end
        if (clr_en) begin
            n_entry = 10'd0;
            n_count = 2'd0;
        end
    end

    // single field write port
    logic        store_ok, wr_en;
    logic [2:0]  wr_slot;
    logic [13:0] wr_val;
    assign store_ok = try_en && (try_val >= cur_lo) && (try_val <= cur_hi);

    always_comb begin
        wr_en    = 1'b0;
        wr_slot  = r_slot;
        wr_val   = force_val;
        n_edited = r_edited;
        if (ld_en) begin
            wr_en   = 1'b1;
            wr_slot = r_in.target_field;
            wr_val  = load_val;
        end else if (force_en) begin
            wr_en    = 1'b1;
            n_edited = r_slot;
        end else if (store_ok) begin
            wr_en    = 1'b1;
            wr_val   = try_val;
            n_edited = r_slot;
        end
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        if (wr_en) begin
            unique case (wr_slot)
                SLOT_YEAR:   n_year   = wr_val;
                SLOT_MONTH:  n_month  = wr_val[3:0];
                SLOT_DAY:    n_day    = wr_val[4:0];
                SLOT_HOUR:   n_hour   = wr_val[4:0];
                SLOT_MINUTE: n_minute = wr_val[5:0];
                default:     n_second = wr_val[5:0];
            endcase
        end
    end

    // cursor advance after a completed entry
    logic [2:0] slot_next;
    assign slot_next = (store_ok && try_adv && (r_slot != SLOT_SECOND)) ? r_slot + 3'd1 : n_slot;

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_year      <= YEAR_RESET;
            r_month     <= 4'd1;
            r_day       <= 5'd1;
            r_hour      <= 5'd0;
            r_minute    <= 6'd0;
            r_second    <= 6'd0;
            r_slot      <= SLOT_YEAR;
            r_edited    <= SLOT_YEAR;
            r_entry     <= 10'd0;
            r_count     <= 2'd0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (process) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (process) begin
                r_year   <= n_year;
                r_month  <= n_month;
                r_day    <= n_day;
                r_hour   <= n_hour;
                r_minute <= n_minute;
                r_second <= n_second;
                r_slot   <= slot_next;
                r_edited <= n_edited;
                r_entry  <= n_entry;
                r_count  <= n_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in <= i_in_data;
        if (process) begin
            r_out.year             <= n_year;
            r_out.month            <= n_month;
            r_out.day              <= n_day;
            r_out.hour             <= n_hour;
            r_out.minute           <= n_minute;
            r_out.second           <= n_second;
            r_out.active_slot      <= slot_next;
            r_out.pending_digits   <= n_entry;
            r_out.pending_count    <= n_count;
            r_out.last_edited_slot <= n_edited;
            r_out.confirmed        <= n_conf;
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the date and time keypad entry block.
// ----------------------------------------------------------------------------
// Key requests go in over the valid/ready input channel. An in-bench editor
// model, updated as each request is accepted, predicts the full view of the
// editor that must come back for it. Each returned view is checked field by
// field against the oldest prediction. The run starts with directed keys over
// the field edges and the special cases. Random typing of whole dates and
// single fields follows, with stepping, loads and raw noise mixed in. Both
// sides idle in random bursts. One long output hold-off fills the block, and
// the run ends with a stream that has no idling at all.
// ----------------------------------------------------------------------------
module tb_top;
    import dtke_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DIGIT_MAX       = 9;
    localparam int FEBRUARY        = 2;

    logic      clk;
    logic      rst_n;
    logic      key_valid;
    logic      key_ready;
    t_in_item  key_req;
    logic      view_valid;
    logic      view_ready;
    t_out_item view_data;

    bit        idling_on;
    int        hold_off_left;
    int        keys_sent;
    int        error_count;
    t_out_item views_due[$];
    t_out_item due_view;

    // editor model state
    logic [13:0] fld [6];
    logic [2:0]  cur_slot;
    logic [2:0]  edit_slot;
    logic [9:0]  ent_digits;
    logic [1:0]  ent_count;

    date_time_keypad_entry DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (key_valid),
        .o_in_ready (key_ready),
        .i_in_data  (key_req),
        .o_out_valid(view_valid),
        .i_out_ready(view_ready),
        .o_out_data (view_data)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // gregorian leap rule
    function automatic bit leap_year(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int slot_low(logic [2:0] s);
        return (s <= SLOT_DAY) ? 1 : 0;
    endfunction

    // upper bound of a field, the day bound following month and year when asked
    function automatic int slot_high(logic [2:0] s, bit by_month);
        case (s)
            SLOT_YEAR:  return YEAR_MAX;
            SLOT_MONTH: return MONTH_MAX;
            SLOT_DAY: begin
                if (!by_month) return DAY_MAX;
                if (fld[SLOT_MONTH] == FEBRUARY) return leap_year(fld[SLOT_YEAR]) ? 29 : 28;
                if (fld[SLOT_MONTH] inside {4, 6, 9, 11}) return 30;
                return 31;
            end
            SLOT_HOUR:  return HOUR_MAX;
            default:    return MINSEC_MAX;
        endcase
    endfunction

    function automatic void clear_pending();
        ent_digits = '0;
        ent_count  = '0;
    endfunction

    // range-checked store into the field under the cursor
    function automatic void store_checked(int v, bit advance);
        if (v >= slot_low(cur_slot) && v <= slot_high(cur_slot, 1'b1)) begin
            fld[cur_slot] = 14'(v);
            edit_slot     = cur_slot;
            if (advance && cur_slot < SLOT_SECOND) cur_slot = cur_slot + 3'd1;
        end
    endfunction

    function automatic void commit_pending();
        if (ent_count != 0) store_checked(ent_digits, 1'b0);
        clear_pending();
    endfunction

    function automatic void type_digit(int d);
        int v;
        if (cur_slot == SLOT_YEAR) begin
            // year completes on its fourth digit
            v = (ent_digits % 1000) * 10 + d;
            if (ent_count >= YEAR_HELD_DIGITS) begin
                store_checked(v, 1'b1);
                clear_pending();
            end else begin
                ent_digits = 10'(v);
                ent_count  = ent_count + 2'd1;
            end
        end else if (ent_count == 0) begin
            // lone digit taken at once when no second digit could fit
            if (d * 10 <= slot_high(cur_slot, 1'b1)) begin
                ent_digits = 10'(d);
                ent_count  = 2'd1;
            end else begin
                store_checked(d, 1'b1);
                clear_pending();
            end
        end else begin
            store_checked((ent_digits % 10) * 10 + d, 1'b1);
            clear_pending();
        end
    endfunction

    // step with wrap, using the month-dependent day bound
    function automatic void step_slot(bit up);
        int lo;
        int hi;
        int v;
        lo = slot_low(cur_slot);
        hi = slot_high(cur_slot, 1'b1);
        v  = fld[cur_slot];
        clear_pending();
        if (up) begin
            v = v + 1;
            if (v > hi) v = lo;
        end else if (v <= lo) begin
            v = hi;
        end else begin
            v = v - 1;
            if (v > hi) v = lo;
        end
        fld[cur_slot] = 14'(v);
        edit_slot     = cur_slot;
    endfunction

    // apply one key to the model and return the view it leaves
    function automatic t_out_item apply_key(t_in_item k);
        t_out_item r;
        int        fv;
        bit        conf;
        conf = 1'b0;
        if (k.load_request) begin
            if (k.target_field <= SLOT_SECOND) begin
                fv = k.field_value;
                if (fv < slot_low(k.target_field)) fv = slot_low(k.target_field);
                if (fv > slot_high(k.target_field, 1'b0)) fv = slot_high(k.target_field, 1'b0);
                fld[k.target_field] = 14'(fv);
            end
        end else begin
            case (k.operation)
                OP_DIGIT: begin
                    if (k.digit <= DIGIT_MAX) type_digit(k.digit);
                end
                OP_JUMP: begin
                    if (k.target_field <= SLOT_SECOND) begin
                        commit_pending();
                        cur_slot = k.target_field;
                        clear_pending();
                    end
                end
                OP_LEFT: begin
                    commit_pending();
                    if (cur_slot > SLOT_YEAR) cur_slot = cur_slot - 3'd1;
                end
                OP_RIGHT: begin
                    commit_pending();
                    if (cur_slot < SLOT_SECOND) cur_slot = cur_slot + 3'd1;
                end
                OP_INCREMENT: step_slot(1'b1);
                OP_DECREMENT: step_slot(1'b0);
                OP_CLEAR:     clear_pending();
                default: begin
                    commit_pending();
                    conf = 1'b1;
                end
            endcase
        end
        r.year             = fld[SLOT_YEAR];
        r.month            = fld[SLOT_MONTH][3:0];
        r.day              = fld[SLOT_DAY][4:0];
        r.hour             = fld[SLOT_HOUR][4:0];
        r.minute           = fld[SLOT_MINUTE][5:0];
        r.second           = fld[SLOT_SECOND][5:0];
        r.active_slot      = cur_slot;
        r.pending_digits   = ent_digits;
        r.pending_count    = ent_count;
        r.last_edited_slot = edit_slot;
        r.confirmed        = conf;
        return r;
    endfunction

    // key builders, unused fields left random
    function automatic t_in_item random_key();
        t_in_item k;
        k.operation    = 3'($urandom_range(0, 7));
        k.load_request = ($urandom_range(0, 7) == 0);
        k.digit        = 4'($urandom_range(0, 15));
        k.target_field = 3'($urandom_range(0, 7));
        k.field_value  = 14'($urandom_range(0, 16383));
        return k;
    endfunction

    function automatic t_in_item key_op(logic [2:0] op);
        t_in_item k;
        k              = random_key();
        k.load_request = 1'b0;
        k.operation    = op;
        return k;
    endfunction

    function automatic t_in_item key_digit(logic [3:0] d);
        t_in_item k;
        k       = key_op(OP_DIGIT);
        k.digit = d;
        return k;
    endfunction

    function automatic t_in_item key_jump(logic [2:0] s);
        t_in_item k;
        k              = key_op(OP_JUMP);
        k.target_field = s;
        return k;
    endfunction

    function automatic t_in_item key_load(logic [2:0] s, logic [13:0] v);
        t_in_item k;
        k              = random_key();
        k.load_request = 1'b1;
        k.target_field = s;
        k.field_value  = v;
        return k;
    endfunction

    // send one request, with an optional idle burst ahead of it
    task automatic offer_key(t_in_item k);
        int gap;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            key_valid <= 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clk);
        end
        key_valid <= 1'b1;
        key_req   <= k;
        do @(posedge clk); while (!key_ready);
        views_due.push_back(apply_key(k));
        keys_sent++;
    endtask

    // result side: random stalls plus the long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        view_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                view_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                view_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                view_ready <= 1'b0;
            end else begin
                view_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, logic [13:0] want_v, logic [13:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endfunction

    // compare each returned view with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && view_valid && view_ready) begin
            if (views_due.size() == 0) begin
                $display("%0t: view with no request outstanding, actual %p", $time, view_data);
                error_count++;
            end else begin
                due_view = views_due.pop_front();
                check_field("year", due_view.year, view_data.year);
                check_field("month", due_view.month, view_data.month);
                check_field("day", due_view.day, view_data.day);
                check_field("hour", due_view.hour, view_data.hour);
                check_field("minute", due_view.minute, view_data.minute);
                check_field("second", due_view.second, view_data.second);
                check_field("active_slot", due_view.active_slot, view_data.active_slot);
                check_field("pending_digits", due_view.pending_digits,
                            view_data.pending_digits);
                check_field("pending_count", due_view.pending_count, view_data.pending_count);
                check_field("last_edited_slot", due_view.last_edited_slot,
                            view_data.last_edited_slot);
                check_field("confirmed", due_view.confirmed, view_data.confirmed);
            end
        end
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // field edges, ignored keys, lone digits, leap days and wrap
    task automatic test_field_edges();
        offer_key(key_op(OP_CLEAR));              // view right after reset
        offer_key(key_op(OP_LEFT));               // cursor stops at year
        repeat (4) offer_key(key_digit(4'd0));    // year zero is dropped
        offer_key(key_load(SLOT_YEAR, 14'd0));    // clamps up to one
        offer_key(key_op(OP_DECREMENT));          // wraps to the top year
        offer_key(key_op(OP_INCREMENT));          // wraps back to one
        offer_key(key_load(SLOT_YEAR, 14'h3FFF)); // clamps down to the top year
        offer_key(key_load(3'd7, 14'd5));         // no such field
        offer_key(key_jump(3'd6));                // no such field
        offer_key(key_jump(SLOT_MONTH));
        offer_key(key_digit(4'd15));              // not a decimal digit
        offer_key(key_digit(4'd5));               // lone month digit, cursor to day
        offer_key(key_load(SLOT_MONTH, 14'd2));
        offer_key(key_load(SLOT_YEAR, 14'd2100)); // century, not leap
        offer_key(key_load(SLOT_DAY, 14'd40));    // clamps to 31
        offer_key(key_op(OP_DECREMENT));          // day above the month limit
        offer_key(key_digit(4'd2));
        offer_key(key_digit(4'd9));               // 29 dropped in a common year
        offer_key(key_load(SLOT_YEAR, 14'd2000));
        offer_key(key_digit(4'd2));
        offer_key(key_digit(4'd9));               // leap day taken
        offer_key(key_digit(4'd3));               // lone hour digit
        offer_key(key_digit(4'd5));
        offer_key(key_op(OP_CONFIRM));            // commits a held minute digit
        offer_key(key_op(OP_RIGHT));
        offer_key(key_op(OP_RIGHT));              // cursor stops at second
        offer_key(key_load(SLOT_SECOND, 14'd60));
        offer_key(key_op(OP_INCREMENT));          // second wraps to zero
        offer_key(key_digit(4'd7));               // lone digit at the last field
        offer_key(key_digit(4'd1));
        offer_key(key_op(OP_CLEAR));
    endtask

    // mostly well-formed typing with random content, plus loads and noise
    task automatic test_random_keys(int goal);
        int          start;
        int          pick;
        int          f;
        int          lead;
        logic [2:0]  s;
        logic [13:0] fv;
        start = keys_sent;
        while (keys_sent - start < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                // whole date typed from the year on
                offer_key(key_jump(SLOT_YEAR));
                repeat (4) offer_key(key_digit(4'($urandom_range(0, DIGIT_MAX))));
                for (f = 1; f < 6; f++) begin
                    lead = (f == SLOT_MONTH) ? 1 : (f == SLOT_DAY) ? 3 : (f == SLOT_HOUR) ? 2 : 5;
                    offer_key(key_digit(4'($urandom_range(0, lead))));
                    offer_key(key_digit(4'($urandom_range(0, DIGIT_MAX))));
                end
            end else if (pick < 45) begin
                // one field typed, then committed, cleared or left pending
                s = 3'($urandom_range(0, 5));
                offer_key(key_jump(s));
                repeat ((s == SLOT_YEAR) ? $urandom_range(1, 4) : $urandom_range(1, 2))
                    offer_key(key_digit(4'($urandom_range(0, DIGIT_MAX))));
                case ($urandom_range(0, 4))
                    0: offer_key(key_op(OP_LEFT));
                    1: offer_key(key_op(OP_RIGHT));
                    2: offer_key(key_op(OP_CONFIRM));
                    3: offer_key(key_op(OP_CLEAR));
                    default: ;
                endcase
            end else if (pick < 60) begin
                // stepping the field under the cursor
                repeat ($urandom_range(1, 8))
                    offer_key(key_op($urandom_range(0, 1) ? OP_INCREMENT : OP_DECREMENT));
            end else if (pick < 75) begin
                // loads leaning toward edges, leap years and february
                case ($urandom_range(0, 3))
                    0:       fv = 14'($urandom_range(0, 16383));
                    1:       fv = 14'($urandom_range(0, 62));
                    2:       fv = 14'(1900 + 4 * $urandom_range(0, 130));
                    default: fv = 14'(FEBRUARY);
                endcase
                offer_key(key_load(3'($urandom_range(0, 6)), fv));
            end else begin
                offer_key(random_key());
            end
        end
    endtask

    // result side holds off while requests keep coming, so the block backs up
    task automatic test_output_hold();
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (40) offer_key(random_key());
    endtask

    initial begin
        rst_n         = 1'b0;
        key_valid     = 1'b0;
        key_req       = '0;
        idling_on     = 1'b0;
        hold_off_left = 0;
        keys_sent     = 0;
        error_count   = 0;
        fld[SLOT_YEAR]   = YEAR_RESET;
        fld[SLOT_MONTH]  = 14'd1;
        fld[SLOT_DAY]    = 14'd1;
        fld[SLOT_HOUR]   = 14'd0;
        fld[SLOT_MINUTE] = 14'd0;
        fld[SLOT_SECOND] = 14'd0;
        cur_slot  = SLOT_YEAR;
        edit_slot = SLOT_YEAR;
        clear_pending();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idling_on = 1'b1;
        test_field_edges();
        test_random_keys(1250);
        idling_on = 1'b0;
        test_output_hold();
        // closing stretch with no idling on either side
        test_random_keys(430);

        @(negedge clk);
        key_valid <= 1'b0;
        while (views_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && views_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
